### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CHK_ASSERT_ANY(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CHK_ASSERT(label, clk, rst_n, prop, msg)
`define CHK_ASSERT_ANY(label, clk, prop, msg)
`endif

`endif

### design/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared constants for the 3x3 matrix inverse.
// ----------------------------------------------------------------------------
package mi3_pkg;

    localparam int DEF_IN_WIDTH  = 16;
    localparam int DEF_IN_FRAC   = 8;
    localparam int DEF_OUT_WIDTH = 32;
    localparam int N_DIM         = 3;
    localparam int N_ENT         = N_DIM * N_DIM;

endpackage

### design/matrix3x3_inverse.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// Pipelined 3x3 matrix inverse by the adjugate, with exact determinant.
// ----------------------------------------------------------------------------
// One matrix is taken per clock and one result leaves per clock while m_tready
// stays high. Along the path from input transfer to result, in order:
// two stages form the cofactors, two the determinant and the magnitudes, one
// sets up the division, a restoring divider resolves one quotient bit per
// stage (OUT_WIDTH + 1 stages) for all nine entries in parallel, and the
// output register adds one; saturation sits before the output register.
// A two-entry output buffer lets the pipeline keep taking items while a
// result waits; input stalls only when both entries are full.

`include "assert_macros.svh"

module matrix3x3_inverse #(
    parameter int IN_WIDTH  = mi3_pkg::DEF_IN_WIDTH,
    parameter int IN_FRAC   = mi3_pkg::DEF_IN_FRAC,
    parameter int OUT_WIDTH = mi3_pkg::DEF_OUT_WIDTH
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // a00 a01 a02 a10 a11 a12 a20 a21 a22, zero padded to bytes
    input  logic [((9 * IN_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // inv00 .. inv22, det, zero padded to bytes
    output logic [((9 * OUT_WIDTH + 3 * IN_WIDTH + 1 + 7) / 8) * 8 - 1:0] m_tdata,
    // singular
    output logic [0:0] m_tuser
);
    import mi3_pkg::*;

    localparam int CW    = 2 * IN_WIDTH + 1;          // signed cofactor
    localparam int PW    = 2 * IN_WIDTH;              // signed 2-term product
    localparam int NW    = 2 * IN_WIDTH;              // cofactor magnitude
    localparam int DETW  = 3 * IN_WIDTH + 1;          // signed determinant
    localparam int DMW   = 3 * IN_WIDTH;              // determinant magnitude
    localparam int DSH   = OUT_WIDTH / 2 + IN_FRAC;
    localparam int QW    = OUT_WIDTH + 1;
    localparam int DVW   = NW + DSH;
    localparam int XW    = ((DVW > DMW + QW) ? DVW : DMW + QW) + 1;
    localparam int NS    = 5 + QW;
    localparam int RESW  = 9 * OUT_WIDTH + DETW + 1;
    localparam int MDW   = ((9 * OUT_WIDTH + DETW + 7) / 8) * 8;

    logic en;
    logic [NS-1:0] v_reg, v_next;

    // front stages
    logic signed [IN_WIDTH-1:0] m_in [N_DIM][N_DIM];
    logic signed [IN_WIDTH-1:0] m0_reg [N_DIM][N_DIM];
    logic signed [PW-1:0] p0_reg [N_DIM][N_DIM], p1_reg [N_DIM][N_DIM];
    logic signed [PW-1:0] p0_next [N_DIM][N_DIM], p1_next [N_DIM][N_DIM];
    logic signed [IN_WIDTH-1:0] r1_reg [N_DIM];
    logic signed [CW-1:0] cof1_reg [N_DIM][N_DIM], cof1_next [N_DIM][N_DIM];
    logic signed [CW-1:0] cof2_reg [N_DIM][N_DIM];
    logic signed [DETW-1:0] dp2_reg [N_DIM];
    logic signed [DETW-1:0] det3_reg, det3_next;
    logic [NW-1:0] num3_reg [N_ENT], num3_next [N_ENT];
    logic [N_ENT-1:0] neg3_reg, neg3_next;
    logic [DMW-1:0] dm3_reg, dm3_next;

    // divider stages; index 0 holds the set-up stage
    logic [XW-1:0] rem_reg [QW+1][N_ENT];
    logic [QW-1:0] q_reg [QW+1][N_ENT];
    logic [N_ENT-1:0] ovf_reg [QW+1];
    logic [N_ENT-1:0] neg_reg [QW+1];
    logic [DMW-1:0] dm_reg [QW+1];
    logic signed [DETW-1:0] det_reg [QW+1];

    // output buffer
    logic out_v_reg, skid_v_reg;
    logic [RESW-1:0] out_d_reg, skid_d_reg, res_d;
    logic push;

    // the pipeline moves as one; the skid entry absorbs a stalled output
    assign en       = !skid_v_reg;
    assign s_tready = en;
    assign push     = en && v_reg[NS-1];

    always_comb
    begin
        v_next = {v_reg[NS-2:0], s_tvalid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= v_next;
        end
    end

    // stage 0: two-term products of every minor
    always_comb
    begin
        int r1, r2, c1, c2;
        for (int r = 0; r < N_DIM; r++)
        begin
            for (int c = 0; c < N_DIM; c++)
            begin
                m_in[r][c] = s_tdata[(r * N_DIM + c) * IN_WIDTH +: IN_WIDTH];
            end
        end
        for (int r = 0; r < N_DIM; r++)
        begin
            for (int c = 0; c < N_DIM; c++)
            begin
                r1 = (r == 0) ? 1 : 0;
                r2 = (r == 2) ? 1 : 2;
                c1 = (c == 0) ? 1 : 0;
                c2 = (c == 2) ? 1 : 2;
                p0_next[r][c] = PW'(m_in[r1][c1]) * PW'(m_in[r2][c2]);
                p1_next[r][c] = PW'(m_in[r1][c2]) * PW'(m_in[r2][c1]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg <= p0_next;
            p1_reg <= p1_next;
            m0_reg <= m_in;
        end
    end

    // stage 1: signed cofactors
    always_comb
    begin
        for (int r = 0; r < N_DIM; r++)
        begin
            for (int c = 0; c < N_DIM; c++)
            begin
                if (((r + c) % 2) == 1)
                begin
                    cof1_next[r][c] = CW'(p1_reg[r][c]) - CW'(p0_reg[r][c]);
                end
                else
                begin
                    cof1_next[r][c] = CW'(p0_reg[r][c]) - CW'(p1_reg[r][c]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cof1_reg <= cof1_next;
            r1_reg   <= m0_reg[0];
        end
    end

    // stage 2: expand the determinant along row 0
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < N_DIM; c++)
            begin
                dp2_reg[c] <= DETW'(r1_reg[c]) * DETW'(cof1_reg[0][c]);
            end
            cof2_reg <= cof1_reg;
        end
    end

    // stage 3: determinant, magnitudes and quotient signs (transposed)
    always_comb
    begin
        logic signed [CW-1:0] cf;
        logic signed [DETW-1:0] ad;
        det3_next = dp2_reg[0] + dp2_reg[1] + dp2_reg[2];
        ad        = det3_next[DETW-1] ? -det3_next : det3_next;
        dm3_next  = ad[DMW-1:0];
        for (int r = 0; r < N_DIM; r++)
        begin
            for (int c = 0; c < N_DIM; c++)
            begin
                cf = cof2_reg[c][r];
                cf = cf[CW-1] ? -cf : cf;
                num3_next[r * N_DIM + c] = cf[NW-1:0];
                neg3_next[r * N_DIM + c] = cof2_reg[c][r][CW-1] ^ det3_next[DETW-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det3_reg <= det3_next;
            num3_reg <= num3_next;
            neg3_reg <= neg3_next;
            dm3_reg  <= dm3_next;
        end
    end

    // stage 4: scale numerators and flag quotients beyond QW bits
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int e = 0; e < N_ENT; e++)
            begin
                rem_reg[0][e] <= XW'(num3_reg[e]) << DSH;
                q_reg[0][e]   <= '0;
                ovf_reg[0][e] <= (XW'(num3_reg[e]) << DSH) >= (XW'(dm3_reg) << QW);
            end
            neg_reg[0] <= neg3_reg;
            dm_reg[0]  <= dm3_reg;
            det_reg[0] <= det3_reg;
        end
    end

    // restoring division, one quotient bit per stage, MSB first
    for (genvar j = 0; j < QW; j++)
    begin : g_div
        localparam int BIT = QW - 1 - j;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int e = 0; e < N_ENT; e++)
                begin
                    if (rem_reg[j][e] >= (XW'(dm_reg[j]) << BIT))
                    begin
                        rem_reg[j+1][e] <= rem_reg[j][e] - (XW'(dm_reg[j]) << BIT);
                        q_reg[j+1][e]   <= q_reg[j][e] | (QW'(1) << BIT);
                    end
                    else
                    begin
                        rem_reg[j+1][e] <= rem_reg[j][e];
                        q_reg[j+1][e]   <= q_reg[j][e];
                    end
                end
                ovf_reg[j+1] <= ovf_reg[j];
                neg_reg[j+1] <= neg_reg[j];
                dm_reg[j+1]  <= dm_reg[j];
                det_reg[j+1] <= det_reg[j];
            end
        end
    end

    // saturate, apply sign, zero the inverse of a singular matrix
    always_comb
    begin
        logic [QW-1:0] mag;
        logic sing;
        sing = (det_reg[QW] == '0);
        for (int e = 0; e < N_ENT; e++)
        begin
            if (neg_reg[QW][e])
            begin
                mag = (ovf_reg[QW][e] || q_reg[QW][e] > (QW'(1) << (OUT_WIDTH - 1)))
                    ? (QW'(1) << (OUT_WIDTH - 1)) : q_reg[QW][e];
                mag = -mag;
            end
            else
            begin
                mag = (ovf_reg[QW][e] || q_reg[QW][e] > ((QW'(1) << (OUT_WIDTH - 1)) - 1'b1))
                    ? ((QW'(1) << (OUT_WIDTH - 1)) - 1'b1) : q_reg[QW][e];
            end
            res_d[e * OUT_WIDTH +: OUT_WIDTH] = sing ? '0 : mag[OUT_WIDTH-1:0];
        end
        res_d[9 * OUT_WIDTH +: DETW] = det_reg[QW];
        res_d[RESW-1]                = sing;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (!out_v_reg || m_tready)
        begin
            if (skid_v_reg)
            begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
            else
            begin
                out_v_reg <= push;
            end
        end
        else if (push)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_v_reg || m_tready)
        begin
            out_d_reg <= skid_v_reg ? skid_d_reg : res_d;
        end
        else if (push)
        begin
            skid_d_reg <= res_d;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = MDW'(out_d_reg[RESW-2:0]);
    assign m_tuser  = out_d_reg[RESW-1];

    `CHK_ASSERT(a_skid_behind_out, clk, rst_n, skid_v_reg |-> out_v_reg, "skid full with empty output")
    `CHK_ASSERT(a_skid_fill, clk, rst_n, $rose(skid_v_reg) |-> $past(out_v_reg && !m_tready), "skid filled without stall")
    `CHK_ASSERT(a_singular_zero, clk, rst_n, (out_v_reg && out_d_reg[RESW-1]) |-> (out_d_reg[9*OUT_WIDTH-1:0] == '0), "singular result with nonzero inverse")

endmodule

### tb/matrix3x3_inverse_tb.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse_tb
// Self-checking bench for the 3x3 matrix inverse: directed corner matrices,
// then random ones, with random idling on both stream sides and results
// checked field by field against a behavioural adjugate model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix3x3_inverse_tb;

    import mi3_pkg::*;

    localparam int IW       = DEF_IN_WIDTH;
    localparam int OW       = DEF_OUT_WIDTH;
    localparam int DW       = 3 * IW + 1;
    localparam int SHIFT    = OW / 2 + DEF_IN_FRAC;
    localparam int S_BITS   = ((9 * IW + 7) / 8) * 8;
    localparam int M_BITS   = ((9 * OW + 3 * IW + 1 + 7) / 8) * 8;
    localparam int LATENCY  = OW + 7;

    typedef struct {
        logic [OW-1:0] inv [N_ENT];
        logic [DW-1:0] det;
        logic          singular;
    } inverse_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_BITS-1:0]   s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_BITS-1:0]   m_tdata;
    logic [0:0]          m_tuser;

    inverse_t expected_inverses [$];
    int       error_count;
    bit       no_idle;

    matrix3x3_inverse dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // a00 a01 a02 a10 a11 a12 a20 a21 a22
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // inv00 .. inv22, det
        .m_tuser  (m_tuser)    // singular
    );

    always #5 clk = ~clk;

    // cofactor * 2^SHIFT / det, truncated toward zero, saturated to OW bits
    function automatic logic [OW-1:0] quotient_sat(longint cof, longint d);
        logic [127:0] cm;
        logic [127:0] dm;
        logic [127:0] q;
        logic [127:0] maxpos;
        bit           neg;
        neg    = (cof < 0) != (d < 0);
        cm     = cof < 0 ? -cof : cof;
        dm     = d < 0 ? -d : d;
        q      = (cm << SHIFT) / dm;
        maxpos = (128'd1 << (OW - 1)) - 1;
        if (neg)
        begin
            if (q > maxpos + 1)
                q = maxpos + 1;
            q = -q;
        end
        else if (q > maxpos)
            q = maxpos;
        return q[OW-1:0];
    endfunction

    function automatic inverse_t invert(logic [IW-1:0] a [N_ENT]);
        longint   m [3][3];
        longint   cof [3][3];
        longint   d;
        inverse_t res;
        for (int i = 0; i < N_ENT; i++)
            m[i / 3][i % 3] = longint'($signed(a[i]));
        d = m[0][0] * m[1][1] * m[2][2] + m[0][1] * m[1][2] * m[2][0]
          + m[0][2] * m[1][0] * m[2][1] - m[0][2] * m[1][1] * m[2][0]
          - m[0][0] * m[1][2] * m[2][1] - m[0][1] * m[1][0] * m[2][2];
        cof[0][0] =   m[1][1] * m[2][2] - m[1][2] * m[2][1];
        cof[0][1] = -(m[1][0] * m[2][2] - m[1][2] * m[2][0]);
        cof[0][2] =   m[1][0] * m[2][1] - m[1][1] * m[2][0];
        cof[1][0] = -(m[0][1] * m[2][2] - m[0][2] * m[2][1]);
        cof[1][1] =   m[0][0] * m[2][2] - m[0][2] * m[2][0];
        cof[1][2] = -(m[0][0] * m[2][1] - m[0][1] * m[2][0]);
        cof[2][0] =   m[0][1] * m[1][2] - m[0][2] * m[1][1];
        cof[2][1] = -(m[0][0] * m[1][2] - m[0][2] * m[1][0]);
        cof[2][2] =   m[0][0] * m[1][1] - m[0][1] * m[1][0];
        for (int i = 0; i < N_ENT; i++)
            res.inv[i] = (d == 0) ? '0 : quotient_sat(cof[i % 3][i / 3], d);
        res.det      = d[DW-1:0];
        res.singular = (d == 0);
        return res;
    endfunction

    // tvalid stays high after the transfer; a next call with an idle gap or the drain drops it
    task automatic send_matrix(logic [IW-1:0] a [N_ENT]);
        int                gap;
        logic [S_BITS-1:0] data;
        gap  = no_idle ? 0 : $urandom_range(0, 17);
        data = '0;
        for (int i = 0; i < N_ENT; i++)
            data[i*IW +: IW] = a[i];
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_inverses = {expected_inverses, invert(a)};
    endtask

    function automatic logic [IW-1:0] rand_entry();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return IW'($signed($urandom_range(0, 1023)) - 512);
            3: return 16'h0100;
            default: return IW'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        logic [IW-1:0] a [N_ENT];
        logic [IW-1:0] corners [6];
        corners = '{16'h8000, 16'h7fff, 16'h0000, 16'h0100, 16'hffff, 16'h0001};
        // identity, scaled identities, zero, repeated rows and all -1 (singular), one regular matrix, then corner picks
        a = '{16'h0100, 0, 0, 0, 16'h0100, 0, 0, 0, 16'h0100};
        send_matrix(a);
        a = '{16'h0001, 0, 0, 0, 16'h0001, 0, 0, 0, 16'h0001};
        send_matrix(a);
        a = '{16'h7fff, 0, 0, 0, 16'h7fff, 0, 0, 0, 16'h7fff};
        send_matrix(a);
        a = '{16'h8000, 0, 0, 0, 16'h8000, 0, 0, 0, 16'h8000};
        send_matrix(a);
        a = '{default: 16'h0000};
        send_matrix(a);
        a = '{16'h8000, 16'h7fff, 16'h1234, 16'h8000, 16'h7fff, 16'h1234, 1, 2, 3};
        send_matrix(a);
        a = '{default: 16'hffff};
        send_matrix(a);
        a = '{16'h0100, 16'h0200, 16'h0300, 16'h0400, 16'h0500, 16'h0600,
              16'h0700, 16'h0800, 16'h0a00};
        send_matrix(a);
        for (int k = 0; k < 12; k++)
        begin
            foreach (a[i])
                a[i] = corners[$urandom_range(0, 5)];
            send_matrix(a);
        end
    endtask

    task automatic test_random(int count);
        logic [IW-1:0] a [N_ENT];
        for (int k = 0; k < count; k++)
        begin
            foreach (a[i])
                a[i] = rand_entry();
            // duplicate a row now and then for singular inputs
            if ($urandom_range(0, 9) == 0)
                for (int c = 0; c < 3; c++)
                    a[6 + c] = a[c];
            no_idle = (k % 400) >= 300;
            send_matrix(a);
        end
        no_idle = 1'b0;
    endtask

    task automatic test_drain_pause();
        s_tvalid <= 1'b0;
        while (expected_inverses.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        inverse_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_inverses.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, m_tdata);
                error_count++;
            end
            else
            begin
                exp_r = expected_inverses.pop_front();
                for (int i = 0; i < N_ENT; i++)
                    if (m_tdata[i*OW +: OW] !== exp_r.inv[i])
                    begin
                        $display("%0t: inv%0d%0d expected %h actual %h", $time,
                                 i / 3, i % 3, exp_r.inv[i], m_tdata[i*OW +: OW]);
                        error_count++;
                    end
                if (m_tdata[9*OW +: DW] !== exp_r.det)
                begin
                    $display("%0t: det expected %h actual %h", $time,
                             exp_r.det, m_tdata[9*OW +: DW]);
                    error_count++;
                end
                if (m_tuser[0] !== exp_r.singular)
                begin
                    $display("%0t: singular expected %b actual %b", $time,
                             exp_r.singular, m_tuser[0]);
                    error_count++;
                end
            end
        end
    end

    // receiver stall: hold tready low for a drawn number of cycles per transfer
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 17);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        no_idle     = 1'b0;
        error_count = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_drain_pause();
        test_random(2000);
        test_drain_pause();
        repeat (LATENCY + 10) @(posedge clk);
        if (error_count == 0)
            $display("** matrix3x3_inverse: PASSED **");
        else
            $display("** matrix3x3_inverse: FAILED **");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("** matrix3x3_inverse: FAILED **");
        $finish;
    end

endmodule
